@@ rtl/core/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue: request kinds,
// response status codes, word type and default depth.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Default number of ring slots
    localparam int unsigned DEQ_DEPTH = 64;

    // Data word and field widths
    localparam int unsigned WORD_W = 32;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned OCC_W  = 7;

    typedef logic signed [WORD_W-1:0] word_t;

    // Request kinds; codes 6 and 7 are ignored
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_REAR  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_REAR   = 3'd3,
        KIND_PUSH_BOTH  = 3'd4,
        KIND_POP_BOTH   = 3'd5
    } kind_t;

    // Response status
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

@@ rtl/core/deq_if.sv @@
// ----------------------------------------------------------------------------
// deq_if
// Valid/ready channels of the double-ended queue: request channel carrying
// kind and value, response channel carrying status, popped words and
// occupancy.
// ----------------------------------------------------------------------------
interface deq_req_if;
    import deq_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    word_t               value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;

    logic                valid;
    logic                ready;
    status_t             status;
    word_t               first_word;
    word_t               second_word;
    logic                second_valid;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, output status, output first_word,
                    output second_word, output second_valid, output occupancy,
                    input ready);
    modport sink   (input valid, input status, input first_word,
                    input second_word, input second_valid, input occupancy,
                    output ready);
endinterface

@@ rtl/core/deq_bank.sv @@
// ----------------------------------------------------------------------------
// deq_bank
// Ring slot store: one write port, two read ports with registered read data.
// Read data holds while read enable is low.
// ----------------------------------------------------------------------------
module deq_bank #(
    parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  deq_pkg::word_t   wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output deq_pkg::word_t   rdata0,
    output deq_pkg::word_t   rdata1
);
    import deq_pkg::*;

    word_t mem [DEPTH];
    word_t rdata0_reg;
    word_t rdata1_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two read ports, registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0_reg <= mem[raddr0];
            rdata1_reg <= mem[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

@@ rtl/core/double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of signed 32-bit words in a ring of DEPTH slots.
// Push/pop at front, rear or both ends; one response per request.
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    kind, value
//   rsp      out  valid/ready    status, first_word, second_word,
//                                second_valid, occupancy
//
// One request per cycle unless a response is stalled; the response appears
// the cycle after acceptance. Pointers update at acceptance; popped words
// come from the registered read ports of the slot banks.
// Words pushed at the front live in the front bank, words pushed at the rear
// in the rear bank; the queue is always front words followed by rear words.
// rst_n clears pointers, counts and response valid; banks need no clearing.
// req.ready is low only while a response waits and rsp.ready is low.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int unsigned DEPTH = deq_pkg::DEQ_DEPTH
) (
    input logic          clk,
    input logic          rst_n,
    deq_req_if.sink      req,
    deq_rsp_if.source    rsp
);
    import deq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);

    typedef struct packed {
        status_t status;
        logic    take0;   // first word returned
        logic    take1;   // second word returned
        logic    sel0;    // first word from front bank
        logic    sel1;    // second word from front bank
    } rsp_ctl_t;

    // (head + off) mod DEPTH, off <= DEPTH
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + (AW + 1)'(off);
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic [CW-1:0]  front_cnt_reg, front_cnt_next;
    logic           rsp_valid_reg;
    rsp_ctl_t       ctl_reg, ctl_next;
    logic [OCC_W-1:0] occ_reg;

    logic           accept;
    kind_t          kind;
    logic [AW-1:0]  head_dec, head_inc, rear_addr, tail_addr;
    logic [CW-1:0]  fill_m1;
    logic           is_empty, is_full, near_full, any_front, all_front;

    logic           wf_en, wr_en;
    logic [AW-1:0]  wf_addr, wr_addr;
    logic [AW-1:0]  raddr0, raddr1;
    word_t          f_rd0, f_rd1, r_rd0, r_rd1;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign kind      = kind_t'(req.kind);

    // Ring positions
    assign fill_m1   = fill_reg - 1'b1;
    assign head_dec  = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc  = ring_add(head_reg, CW'(1));
    assign rear_addr = ring_add(head_reg, fill_m1);
    assign tail_addr = ring_add(head_reg, fill_reg);

    assign is_empty  = (fill_reg == '0);
    assign is_full   = (fill_reg == DEPTH_C);
    assign near_full = (fill_reg >= DEPTH_C - 1'b1);
    assign any_front = (front_cnt_reg != '0);
    assign all_front = (front_cnt_reg == fill_reg);

    // Request decode: next pointers, bank writes, read selection
    always_comb
    begin
        head_next      = head_reg;
        fill_next      = fill_reg;
        front_cnt_next = front_cnt_reg;
        wf_en          = 1'b0;
        wr_en          = 1'b0;
        wf_addr        = head_dec;
        wr_addr        = tail_addr;
        raddr0         = head_reg;
        raddr1         = rear_addr;
        ctl_next       = '{status: ST_OK, take0: 1'b0, take1: 1'b0,
                           sel0: any_front, sel1: all_front};
        case (kind)
            KIND_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    ctl_next.status = ST_FULL;
                end
                else
                begin
                    wf_en          = 1'b1;
                    head_next      = head_dec;
                    fill_next      = fill_reg + 1'b1;
                    front_cnt_next = front_cnt_reg + 1'b1;
                end
            end
            KIND_PUSH_REAR:
            begin
                if (is_full)
                begin
                    ctl_next.status = ST_FULL;
                end
                else
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            KIND_POP_FRONT:
            begin
                if (is_empty)
                begin
                    ctl_next.status = ST_EMPTY;
                end
                else
                begin
                    ctl_next.take0 = 1'b1;
                    head_next      = head_inc;
                    fill_next      = fill_m1;
                    if (any_front)
                    begin
                        front_cnt_next = front_cnt_reg - 1'b1;
                    end
                end
            end
            KIND_POP_REAR:
            begin
                if (is_empty)
                begin
                    ctl_next.status = ST_EMPTY;
                end
                else
                begin
                    ctl_next.take0 = 1'b1;
                    ctl_next.sel0  = all_front;
                    raddr0         = rear_addr;
                    fill_next      = fill_m1;
                    if (all_front)
                    begin
                        front_cnt_next = front_cnt_reg - 1'b1;
                    end
                end
            end
            KIND_PUSH_BOTH:
            begin
                if (is_empty)
                begin
                    // single copy at the head slot
                    wr_en     = 1'b1;
                    fill_next = CW'(1);
                end
                else if (near_full)
                begin
                    ctl_next.status = ST_FULL;
                end
                else
                begin
                    wr_en          = 1'b1;
                    wf_en          = 1'b1;
                    head_next      = head_dec;
                    fill_next      = fill_reg + CW'(2);
                    front_cnt_next = front_cnt_reg + 1'b1;
                end
            end
            KIND_POP_BOTH:
            begin
                if (is_empty)
                begin
                    ctl_next.status = ST_EMPTY;
                end
                else if (fill_reg == CW'(1))
                begin
                    ctl_next.take0 = 1'b1;
                    fill_next      = '0;
                    front_cnt_next = '0;
                end
                else
                begin
                    ctl_next.take0 = 1'b1;
                    ctl_next.take1 = 1'b1;
                    head_next      = head_inc;
                    fill_next      = fill_reg - CW'(2);
                    if (all_front)
                    begin
                        front_cnt_next = front_cnt_reg - CW'(2);
                    end
                    else if (any_front)
                    begin
                        front_cnt_next = front_cnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                // unknown kind: no change, status ok
            end
        endcase
    end

    // Front-pushed words
    deq_bank #(.DEPTH(DEPTH), .AW(AW)) u_front_bank (
        .clk    (clk),
        .we     (accept && wf_en),
        .waddr  (wf_addr),
        .wdata  (req.value),
        .re     (accept),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (f_rd0),
        .rdata1 (f_rd1)
    );

    // Rear-pushed words
    deq_bank #(.DEPTH(DEPTH), .AW(AW)) u_rear_bank (
        .clk    (clk),
        .we     (accept && wr_en),
        .waddr  (wr_addr),
        .wdata  (req.value),
        .re     (accept),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (r_rd0),
        .rdata1 (r_rd1)
    );

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            front_cnt_reg <= '0;
        end
        else if (accept)
        begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            front_cnt_reg <= front_cnt_next;
        end
    end

    // Response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg <= ctl_next;
            occ_reg <= OCC_W'(fill_next);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = ctl_reg.status;
    assign rsp.first_word   = !ctl_reg.take0 ? '0 : (ctl_reg.sel0 ? f_rd0 : r_rd0);
    assign rsp.second_word  = !ctl_reg.take1 ? '0 : (ctl_reg.sel1 ? f_rd1 : r_rd1);
    assign rsp.second_valid = ctl_reg.take1;
    assign rsp.occupancy    = occ_reg;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("fill count above depth");

    a_front_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        front_cnt_reg <= fill_reg)
        else $error("front word count above fill count");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request gave no response");

    a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (occ_reg == OCC_W'(fill_reg)))
        else $error("reported occupancy differs from fill count");

    a_second_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && ctl_reg.take1) |-> (ctl_reg.status == ST_OK && ctl_reg.take0))
        else $error("second word without ok status");

endmodule
